/* rtl/velocity_verlet_particle_update_defines.svh */
// Assertion macros shared by the particle update RTL.
`ifndef VELOCITY_VERLET_PARTICLE_UPDATE_DEFINES_SVH
`define VELOCITY_VERLET_PARTICLE_UPDATE_DEFINES_SVH

// Check cons in the same cycle as ante.
`define VVPU_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante.
`define VVPU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/vvpu_pkg.sv */
// Shared widths, latencies and types for the particle update pipeline.
`timescale 1ns / 1ps
package vvpu_pkg;

  localparam int DATA_W       = 32;  // signed Q16.16 vector component
  localparam int TS_W         = 31;  // unsigned Q15.16 time step and density
  localparam int DIMS_W       = 2;
  localparam int NUM_DIMS     = 3;
  localparam int MAX_DIMS_DEF = 3;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;

  localparam int IN_DATA_W  = 320;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 2 * NUM_DIMS * DATA_W;

  // Kick division: 62-bit dividend, 32-bit divisor, 35 quotient bits.
  localparam int NUM_W   = 62;
  localparam int DEN_W   = 32;
  localparam int QUO_W   = 35;
  localparam int DIV_LAT = QUO_W + 1;

  // Three stages before the divider, six after it.
  localparam int PIPE_LAT = 3 + DIV_LAT + 6;

  typedef struct packed {
    logic [DATA_W-1:0] vel;
    logic [DATA_W-1:0] pos;
    logic              upd;
    logic              kick_only;
    logic              f_neg;
    logic              f_zero;
  } div_side_t;

endpackage

/* rtl/vvpu_div.sv */
// Pipelined restoring divider, one quotient bit per stage, for the kick term.
`timescale 1ns / 1ps
module vvpu_div (
  input  logic                          clk,
  input  logic                          en,
  input  logic [vvpu_pkg::NUM_W-1:0]    num,
  input  logic [vvpu_pkg::DEN_W-1:0]    den,
  input  vvpu_pkg::div_side_t           side_in,
  output logic [vvpu_pkg::QUO_W-1:0]    quo,
  output logic                          ovf,
  output vvpu_pkg::div_side_t           side_out
);
  import vvpu_pkg::*;

  logic [DEN_W-1:0] rem    [0:QUO_W];
  logic [QUO_W-1:0] dvd    [0:QUO_W];
  logic [QUO_W-1:0] q      [0:QUO_W];
  logic [DEN_W-1:0] dsr    [0:QUO_W];
  logic             ovf_s  [0:QUO_W];
  div_side_t        side_s [0:QUO_W];

  logic [DEN_W:0]   trial  [1:QUO_W];
  logic             ge     [1:QUO_W];

  always_comb begin
    for (int j = 1; j <= QUO_W; j++) begin
      trial[j] = {rem[j-1], dvd[j-1][QUO_W-1]};
      ge[j]    = trial[j] >= {1'b0, dsr[j-1]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // Quotient needs more than QUO_W bits when the high part reaches the divisor.
      rem[0]    <= DEN_W'(num[NUM_W-1:QUO_W]);
      dvd[0]    <= num[QUO_W-1:0];
      q[0]      <= '0;
      dsr[0]    <= den;
      ovf_s[0]  <= DEN_W'(num[NUM_W-1:QUO_W]) >= den;
      side_s[0] <= side_in;
      for (int j = 1; j <= QUO_W; j++) begin
        rem[j]    <= ge[j] ? DEN_W'(trial[j] - {1'b0, dsr[j-1]}) : trial[j][DEN_W-1:0];
        dvd[j]    <= {dvd[j-1][QUO_W-2:0], 1'b0};
        q[j]      <= {q[j-1][QUO_W-2:0], ge[j]};
        dsr[j]    <= dsr[j-1];
        ovf_s[j]  <= ovf_s[j-1];
        side_s[j] <= side_s[j-1];
      end
    end
  end

  assign quo      = q[QUO_W];
  assign ovf      = ovf_s[QUO_W];
  assign side_out = side_s[QUO_W];

endmodule

/* rtl/vvpu_lane.sv */
// One spatial dimension of the update: kick, velocity sum, drift and position sum.
`timescale 1ns / 1ps
module vvpu_lane (
  input  logic                              clk,
  input  logic                              en,
  input  logic [vvpu_pkg::TS_W-1:0]         dt,
  input  logic [vvpu_pkg::TS_W-1:0]         rho,
  input  logic signed [vvpu_pkg::DATA_W-1:0] frc_in,
  input  logic signed [vvpu_pkg::DATA_W-1:0] vel_in,
  input  logic signed [vvpu_pkg::DATA_W-1:0] pos_in,
  input  logic                              upd,
  input  logic                              kick_only,
  output logic signed [vvpu_pkg::DATA_W-1:0] vel_out,
  output logic signed [vvpu_pkg::DATA_W-1:0] pos_out
);
  import vvpu_pkg::*;

  localparam int MUL_W  = DATA_W + TS_W;
  localparam int SUM_W  = 48;
  localparam int FRAC_W = 16;
  localparam int DMAG_W = NUM_W - FRAC_W;

  localparam logic [QUO_W-1:0] KICK_LIM = QUO_W'(1) << (QUO_W - 1);
  localparam logic [NUM_W-1:0] RND_HALF = NUM_W'(1) << (FRAC_W - 1);
  localparam logic signed [SUM_W-1:0] SAT_HI =
    {{(SUM_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SAT_LO = ~SAT_HI;

  function automatic logic [DATA_W-1:0] sat_data(input logic signed [SUM_W-1:0] x);
    if (x > SAT_HI) return SAT_HI[DATA_W-1:0];
    else if (x < SAT_LO) return SAT_LO[DATA_W-1:0];
    else return x[DATA_W-1:0];
  endfunction

  // stage 1: force magnitude
  logic [DATA_W-1:0] f_mag1;
  logic [TS_W-1:0]   rho1;
  div_side_t         side1;
  // stage 2: |F| * dt
  logic [NUM_W-1:0]  prod2;
  logic [TS_W-1:0]   rho2;
  div_side_t         side2;
  // stage 3: add rho for rounding, form 2 * rho
  logic [NUM_W-1:0]  numr3;
  logic [DEN_W-1:0]  den3;
  div_side_t         side3;
  // divider output
  logic [QUO_W-1:0]  quo_d;
  logic              ovf_d;
  div_side_t         side_d;
  // stage K1: signed, clamped kick
  logic signed [QUO_W:0] kick4;
  div_side_t         side4;
  // stage K2: new velocity
  logic signed [DATA_W-1:0] vnew5;
  div_side_t         side5;
  // stage M1: velocity magnitude
  logic [DATA_W-1:0] vmag6;
  logic              vneg6;
  logic [DATA_W-1:0] vnew6;
  div_side_t         side6;
  // stage M2: |v'| * dt
  logic [NUM_W-1:0]  prod7;
  logic              vneg7;
  logic [DATA_W-1:0] vnew7;
  div_side_t         side7;
  // stage R1: rounded drift magnitude
  logic [DMAG_W-1:0] dmag8;
  logic              vneg8;
  logic [DATA_W-1:0] vnew8;
  div_side_t         side8;

  logic [MUL_W-1:0]  mul_f;
  logic [MUL_W-1:0]  mul_v;
  logic [QUO_W-1:0]  kmag;
  logic signed [SUM_W-1:0] vsum;
  logic [NUM_W-1:0]  rnd;
  logic signed [SUM_W-1:0] pos_x;
  logic signed [SUM_W-1:0] dsx;
  logic signed [SUM_W-1:0] psum;
  logic [DATA_W-1:0] pnew;

  always_comb begin
    mul_f = f_mag1 * dt;
    mul_v = vmag6 * dt;
    kmag  = (ovf_d || quo_d > KICK_LIM) ? KICK_LIM : quo_d;
    vsum  = SUM_W'($signed(side4.vel)) + SUM_W'(kick4);
    rnd   = prod7 + RND_HALF;
    pos_x = SUM_W'($signed(side8.pos));
    dsx   = SUM_W'($signed({1'b0, dmag8}));
    psum  = vneg8 ? pos_x - dsx : pos_x + dsx;
    pnew  = sat_data(psum);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_mag1          <= frc_in[DATA_W-1] ? $unsigned(-frc_in) : $unsigned(frc_in);
      rho1            <= rho;
      side1.vel       <= vel_in;
      side1.pos       <= pos_in;
      side1.upd       <= upd;
      side1.kick_only <= kick_only;
      side1.f_neg     <= frc_in[DATA_W-1];
      side1.f_zero    <= frc_in == '0;

      prod2 <= mul_f[NUM_W-1:0];
      rho2  <= rho1;
      side2 <= side1;

      numr3 <= prod2 + NUM_W'(rho2);
      den3  <= {rho2, 1'b0};
      side3 <= side2;

      // zero force gives zero kick even when the density is zero
      if (side_d.f_zero) kick4 <= '0;
      else if (side_d.f_neg) kick4 <= -$signed({1'b0, kmag});
      else kick4 <= $signed({1'b0, kmag});
      side4 <= side_d;

      vnew5 <= sat_data(vsum);
      side5 <= side4;

      vmag6 <= vnew5[DATA_W-1] ? $unsigned(-vnew5) : $unsigned(vnew5);
      vneg6 <= vnew5[DATA_W-1];
      vnew6 <= vnew5;
      side6 <= side5;

      prod7 <= mul_v[NUM_W-1:0];
      vneg7 <= vneg6;
      vnew7 <= vnew6;
      side7 <= side6;

      dmag8 <= rnd[NUM_W-1:FRAC_W];
      vneg8 <= vneg7;
      vnew8 <= vnew7;
      side8 <= side7;

      vel_out <= side8.upd ? vnew8 : side8.vel;
      pos_out <= (side8.upd && !side8.kick_only) ? pnew : side8.pos;
    end
  end

  vvpu_div u_div (
    .clk      (clk),
    .en       (en),
    .num      (numr3),
    .den      (den3),
    .side_in  (side3),
    .quo      (quo_d),
    .ovf      (ovf_d),
    .side_out (side_d)
  );

endmodule

/* rtl/vvpu_out_buf.sv */
// Two-entry output register with skid slot for the result stream.
`timescale 1ns / 1ps
`include "velocity_verlet_particle_update_defines.svh"
module vvpu_out_buf (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  input  logic [vvpu_pkg::OUT_DATA_W-1:0]  push_data,
  output logic                             space,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [vvpu_pkg::OUT_DATA_W-1:0]  m_tdata
);
  import vvpu_pkg::*;

  logic [1:0]            count;
  logic [1:0]            count_next;
  logic [OUT_DATA_W-1:0] skid;
  logic                  pop;

  assign m_tvalid   = count != 2'd0;
  assign pop        = m_tvalid && m_tready;
  assign space      = (count != 2'd2) || m_tready;
  assign count_next = count + {1'b0, push} - {1'b0, pop};

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    case (count)
      2'd0: begin
        if (push) m_tdata <= push_data;
      end
      2'd1: begin
        if (push && pop) m_tdata <= push_data;
        else if (push) skid <= push_data;
      end
      default: begin
        // full: advance the skid item, refill behind it
        if (pop) begin
          m_tdata <= skid;
          if (push) skid <= push_data;
        end
      end
    endcase
  end

  `VVPU_ASSERT_IMPL(a_no_overrun, clk, rst, push && (count == 2'd2), pop, "push into full buffer")
  `VVPU_ASSERT_NEXT(a_skid_advance, clk, rst, pop && !push && (count == 2'd2), m_tvalid && (count == 2'd1), "skid item lost")

endmodule

/* rtl/velocity_verlet_particle_update.sv */
// Velocity Verlet particle update: top level with config, valid pipeline and lanes.
// The block takes one particle per clock while s_tready is high and returns one
// result per particle, in order, through 45 register stages (three for the force
// magnitude, the F*dt product and the rounding add, 36 for the one-bit-per-stage
// kick divider, six for the velocity sum, the drift product and the position sum)
// and the output register. A two-entry output buffer keeps the pipeline moving while
// one result waits; when both entries are full, m_tready is low and the last stage
// holds a result, all stages hold and s_tready falls. The user writes time_step
// and dims_in_use only while no particle is in flight; the block does not check it.
`timescale 1ns / 1ps
`include "velocity_verlet_particle_update_defines.svh"
module velocity_verlet_particle_update #(
  parameter int MAX_DIMS = vvpu_pkg::MAX_DIMS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // density[30:0], force_x, force_y, force_z, vel_in_x, vel_in_y, vel_in_z,
  // pos_in_x, pos_in_y, pos_in_z (32 bits each from bit 31 up), zero pad
  input  logic [vvpu_pkg::IN_DATA_W-1:0]   s_tdata,
  // opcode[0], is_fixed[1]
  input  logic [vvpu_pkg::IN_USER_W-1:0]   s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // vel_out_x, vel_out_y, vel_out_z, pos_out_x, pos_out_y, pos_out_z, 32 bits each
  output logic [vvpu_pkg::OUT_DATA_W-1:0]  m_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [vvpu_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [vvpu_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import vvpu_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_DIMS      = CFG_IDX_W'(1);
  localparam logic [TS_W-1:0]      TS_RESET      = TS_W'(65);
  localparam logic [DIMS_W-1:0]    DIMS_RESET    = DIMS_W'(3);
  localparam logic [DIMS_W-1:0]    DIMS_CAP      = DIMS_W'(MAX_DIMS);

  logic [TS_W-1:0]          time_step;
  logic [DIMS_W-1:0]        dims_in_use;
  logic [DIMS_W-1:0]        dims_lim;

  logic                     opcode;
  logic                     is_fixed;
  logic [TS_W-1:0]          density;
  logic signed [DATA_W-1:0] frc_in [NUM_DIMS];
  logic signed [DATA_W-1:0] vel_in [NUM_DIMS];
  logic signed [DATA_W-1:0] pos_in [NUM_DIMS];
  logic [NUM_DIMS-1:0]      upd;
  logic signed [DATA_W-1:0] vel_res [NUM_DIMS];
  logic signed [DATA_W-1:0] pos_res [NUM_DIMS];

  logic [PIPE_LAT-1:0]      vld;
  logic                     adv;
  logic                     buf_space;
  logic [OUT_DATA_W-1:0]    res_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_step   <= TS_RESET;
      dims_in_use <= DIMS_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_TIME_STEP: time_step   <= cfg_data[TS_W-1:0];
        REG_DIMS:      dims_in_use <= cfg_data[DIMS_W-1:0];
        default: ;
      endcase
    end
  end

  assign dims_lim = (dims_in_use > DIMS_CAP) ? DIMS_CAP : dims_in_use;

  assign opcode   = s_tuser[0];
  assign is_fixed = s_tuser[1];
  assign density  = s_tdata[TS_W-1:0];

  // hold every stage while the last one cannot hand its result on
  assign adv      = !vld[PIPE_LAT-1] || buf_space;
  assign s_tready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[PIPE_LAT-2:0], s_tvalid};
    end
  end

  for (genvar d = 0; d < NUM_DIMS; d++) begin : g_dim
    assign frc_in[d] = s_tdata[TS_W + d * DATA_W +: DATA_W];
    assign vel_in[d] = s_tdata[TS_W + (NUM_DIMS + d) * DATA_W +: DATA_W];
    assign pos_in[d] = s_tdata[TS_W + (2 * NUM_DIMS + d) * DATA_W +: DATA_W];
    assign upd[d]    = !is_fixed && (DIMS_W'(d) < dims_lim);

    if (d < MAX_DIMS) begin : g_lane
      vvpu_lane u_lane (
        .clk       (clk),
        .en        (adv),
        .dt        (time_step),
        .rho       (density),
        .frc_in    (frc_in[d]),
        .vel_in    (vel_in[d]),
        .pos_in    (pos_in[d]),
        .upd       (upd[d]),
        .kick_only (opcode),
        .vel_out   (vel_res[d]),
        .pos_out   (pos_res[d])
      );
    end else begin : g_pass
      // dimension never updated: delay it to line up with the lanes
      logic [2*DATA_W-1:0] dly [PIPE_LAT];
      always_ff @(posedge clk) begin
        if (adv) begin
          dly[0] <= {pos_in[d], vel_in[d]};
          for (int i = 1; i < PIPE_LAT; i++) dly[i] <= dly[i-1];
        end
      end
      assign vel_res[d] = dly[PIPE_LAT-1][DATA_W-1:0];
      assign pos_res[d] = dly[PIPE_LAT-1][2*DATA_W-1:DATA_W];
    end

    assign res_data[d * DATA_W +: DATA_W]              = vel_res[d];
    assign res_data[(NUM_DIMS + d) * DATA_W +: DATA_W] = pos_res[d];
  end

  vvpu_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (adv && vld[PIPE_LAT-1]),
    .push_data (res_data),
    .space     (buf_space),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  `VVPU_ASSERT_NEXT(a_hold_on_stall, clk, rst, !adv, vld == $past(vld), "valid bits moved in a stall")

endmodule
